// ----- hdl/sbc_pkg.sv -----
// SHA-256 block compression: shared types and constants.
// Holds the beat structs, the sequencer-to-datapath control struct and the round tables.
// No dependencies.
package sbc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned RoundW  = $clog2(Rounds);
  localparam int unsigned BlkWords = 16;
  localparam int unsigned PosW    = $clog2(BlkWords);
  localparam int unsigned HashWords = 8;
  localparam int unsigned IdxW    = $clog2(HashWords);

  typedef logic [WordW-1:0] word_t;

  // Input beat: one message word
  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             first_of_message;
    logic             final_block;
  } in_beat_t;

  // Output beat: one digest word
  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [IdxW-1:0]  word_index;
    logic             last;
  } out_beat_t;

  // Sequencer controls for the schedule and the round core
  typedef struct packed {
    logic load_word;    // shift an incoming message word into the schedule
    logic round_en;     // run one round, expand the schedule by one word
    logic init_vars;    // working variables take the hash state
    logic hash_reload;  // hash state takes the initial values
    logic hash_add;     // hash state accumulates the working variables
  } ctrl_t;

  localparam word_t InitHash [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

endpackage

// ----- hdl/sha256_block_compress_unit.sv -----
// SHA-256 block compression unit, one message word per input beat.
// In beats carry padded big-endian message words; each 16th word of a block
// starts 64 rounds on a single shared round unit, one round per cycle.
// Input beat: message_word, first_of_message (restarts the hash from the
// initial values and drops any partial block), final_block (sampled on the
// 16th word only). Output beat: digest_word, word_index 0..7, last on index 7.
// Words 1..15 of a block are taken whenever in_valid_i is high. After the
// 16th word in_ready_o is low through the round loop and the hash update.
// For a final block the eight digest beats follow, one per cycle when the
// receiver keeps out_ready_i high; in_ready_o stays low until the eighth
// is loaded into the output register.
// A stalled receiver holds the output register and the digest sequence
// waits; input is accepted again once the last beat is in the register.
// Reset (rst_ni low) loads the initial hash values, clears the word count
// and the sequencer, and drops any output beat.
// Depends on sbc_pkg, sbc_schedule, sbc_core.
module sha256_block_compress_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sbc_pkg::in_beat_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sbc_pkg::out_beat_t   out_data_o
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_e;

  state_e                       state_q;
  logic [sbc_pkg::PosW-1:0]     pos_q;
  logic [sbc_pkg::RoundW-1:0]   round_q;
  logic [sbc_pkg::IdxW-1:0]     emit_q;
  logic                         final_q;
  logic                         out_valid_q;
  sbc_pkg::out_beat_t           out_data_q;

  sbc_pkg::ctrl_t               ctrl;
  sbc_pkg::word_t               w, rd_word;
  logic                         in_accept, block_done, emit_load;

  // Sequencer controls
  assign in_accept  = in_valid_i && (state_q == ST_LOAD);
  assign block_done = !in_data_i.first_of_message && (pos_q == sbc_pkg::PosW'(15));
  assign emit_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctrl.load_word   = in_accept;
    ctrl.round_en    = (state_q == ST_ROUND);
    ctrl.init_vars   = in_accept && block_done;
    ctrl.hash_reload = in_accept && in_data_i.first_of_message;
    ctrl.hash_add    = (state_q == ST_FINISH);
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      pos_q       <= '0;
      round_q     <= '0;
      emit_q      <= '0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // a taken beat empties the register unless the next one loads now
      if (out_valid_q && out_ready_i && !emit_load) out_valid_q <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (in_accept) begin
            if (block_done) begin
              pos_q   <= '0;
              round_q <= '0;
              final_q <= in_data_i.final_block;
              state_q <= ST_ROUND;
            end else if (in_data_i.first_of_message) begin
              pos_q <= sbc_pkg::PosW'(1);
            end else begin
              pos_q <= pos_q + 1'b1;
            end
          end
        end
        ST_ROUND: begin
          round_q <= round_q + 1'b1;
          if (round_q == sbc_pkg::RoundW'(sbc_pkg::Rounds - 1)) state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          emit_q  <= '0;
          state_q <= final_q ? ST_EMIT : ST_LOAD;
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_valid_q            <= 1'b1;
            out_data_q.digest_word <= rd_word;
            out_data_q.word_index  <= emit_q;
            out_data_q.last        <= (emit_q == sbc_pkg::IdxW'(sbc_pkg::HashWords - 1));
            emit_q                 <= emit_q + 1'b1;
            if (emit_q == sbc_pkg::IdxW'(sbc_pkg::HashWords - 1)) state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  sbc_schedule u_schedule (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .word_i (in_data_i.message_word),
    .w_o    (w)
  );

  sbc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .round_i   (round_q),
    .w_i       (w),
    .rd_idx_i  (emit_q),
    .rd_word_o (rd_word)
  );

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hdl/sbc_schedule.sv -----
// SHA-256 message schedule: 16-word rolling window with one-word expander.
// Depends on sbc_pkg.
module sbc_schedule (
  input  logic               clk_i,
  input  sbc_pkg::ctrl_t     ctrl_i,
  input  sbc_pkg::word_t     word_i,
  output sbc_pkg::word_t     w_o
);

  sbc_pkg::word_t win_q [sbc_pkg::BlkWords];
  sbc_pkg::word_t win_d [sbc_pkg::BlkWords];
  sbc_pkg::word_t s0, s1, x1, x14, next_w;

  // Small sigma functions on fixed taps
  assign x1     = win_q[1];
  assign x14    = win_q[14];
  assign s0     = {x1[6:0], x1[31:7]} ^ {x1[17:0], x1[31:18]} ^ (x1 >> 3);
  assign s1     = {x14[16:0], x14[31:17]} ^ {x14[18:0], x14[31:19]} ^ (x14 >> 10);
  assign next_w = win_q[0] + s0 + s1 + win_q[9];

  // Window shifts toward tap 0; new word enters at the top
  always_comb begin
    for (int i = 0; i < sbc_pkg::BlkWords - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[sbc_pkg::BlkWords-1] = ctrl_i.load_word ? word_i : next_w;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_word || ctrl_i.round_en) begin
      win_q <= win_d;
    end
  end

  assign w_o = win_q[0];

endmodule

// ----- hdl/sbc_core.sv -----
// SHA-256 round core: working variables, one shared round unit, hash state.
// Depends on sbc_pkg.
module sbc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sbc_pkg::ctrl_t              ctrl_i,
  input  logic [sbc_pkg::RoundW-1:0]  round_i,
  input  sbc_pkg::word_t              w_i,
  input  logic [sbc_pkg::IdxW-1:0]    rd_idx_i,
  output sbc_pkg::word_t              rd_word_o
);

  sbc_pkg::word_t v_q [sbc_pkg::HashWords];
  sbc_pkg::word_t v_d [sbc_pkg::HashWords];
  sbc_pkg::word_t hash_q [sbc_pkg::HashWords];
  sbc_pkg::word_t a, e, big0, big1, ch, maj, t1, t2;

  // Round function
  assign a    = v_q[0];
  assign e    = v_q[4];
  assign big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ch   = (e & v_q[5]) ^ (~e & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + sbc_pkg::RoundK[round_i] + w_i;
  assign big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign maj  = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  always_comb begin
    v_d[7] = v_q[6];
    v_d[6] = v_q[5];
    v_d[5] = v_q[4];
    v_d[4] = v_q[3] + t1;
    v_d[3] = v_q[2];
    v_d[2] = v_q[1];
    v_d[1] = v_q[0];
    v_d[0] = t1 + t2;
  end

  // Working variables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbc_pkg::HashWords; i++) v_q[i] <= '0;
    end else if (ctrl_i.init_vars) begin
      v_q <= hash_q;
    end else if (ctrl_i.round_en) begin
      v_q <= v_d;
    end
  end

  // Hash state: reload or accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= sbc_pkg::InitHash;
    end else if (ctrl_i.hash_reload) begin
      hash_q <= sbc_pkg::InitHash;
    end else if (ctrl_i.hash_add) begin
      for (int i = 0; i < sbc_pkg::HashWords; i++) hash_q[i] <= hash_q[i] + v_q[i];
    end
  end

  assign rd_word_o = hash_q[rd_idx_i];

endmodule

// ----- hdl/sbc_checker.sv -----
// Port-level checker for the SHA-256 block compression unit, with its bind.
// Depends on sbc_pkg and sha256_block_compress_unit.
module sbc_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_ready_o,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  sbc_pkg::out_beat_t  out_data_o
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Last marker only on the eighth digest word
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.word_index == 3'd7)))
    else $error("last marker does not match word index");

  // Digest beats follow back to back once one is taken
  a_digest_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside digest sequence");

  // No input taken while a digest sequence is still pending
  a_no_in_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input ready during digest sequence");

endmodule

bind sha256_block_compress_unit sbc_checker u_sbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
